FILE: rtl/qte_pkg.sv
package qte_pkg;

    localparam int MAX_LEN_W   = 9;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int RES_MAX     = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;
    localparam int STALL_LEVEL = FIFO_DEPTH - 2 * RES_MAX;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 9'd256;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [1:0] REG_MAX_LEN    = 2'd0;
    localparam logic [1:0] REG_ADD_BSL    = 2'd1;
    localparam logic [1:0] REG_STRIP_BSL  = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'b001,
        PH_TOKEN = 3'b010,
        PH_DONE  = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        QM_OUT   = 3'b001,
        QM_IN    = 3'b010,
        QM_AFTER = 3'b100
    } t_quote;

    typedef struct packed {
        logic [MAX_LEN_W-1:0] max_len;
        logic                 add_bsl;
        logic                 strip_bsl;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_done;
        logic [7:0] name_length;
        logic       has_space;
    } t_result;

endpackage

FILE: rtl/qte_cfg.sv
module qte_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qte_pkg::ADDR_W-1:0]  paddr,
    input  logic [qte_pkg::DATA_W-1:0]  pwdata,
    output logic [qte_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output qte_pkg::t_cfg               o_cfg
);
    import qte_pkg::*;

    logic [1:0] reg_idx;
    logic       wr_en;
    t_cfg       r_cfg;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len   <= MAX_LEN_RESET;
            r_cfg.add_bsl   <= 1'b0;
            r_cfg.strip_bsl <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_LEN:   r_cfg.max_len   <= pwdata[MAX_LEN_W-1:0];
                REG_ADD_BSL:   r_cfg.add_bsl   <= pwdata[0];
                REG_STRIP_BSL: r_cfg.strip_bsl <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_MAX_LEN:   prdata[MAX_LEN_W-1:0] = r_cfg.max_len;
            REG_ADD_BSL:   prdata[0] = r_cfg.add_bsl;
            REG_STRIP_BSL: prdata[0] = r_cfg.strip_bsl;
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: rtl/qte_core.sv
module qte_core #(
    parameter int MAX_NAME = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [7:0]                               i_byte,
    input  logic                                     i_line_end,
    input  qte_pkg::t_cfg                            i_cfg,
    output logic [1:0]                               o_push_cnt,
    output qte_pkg::t_result [qte_pkg::RES_MAX-1:0]  o_push
);
    import qte_pkg::*;

    localparam int MAX_LEN_TOP = (1 << MAX_LEN_W) - 1;
    localparam int CLAMP       = (MAX_NAME > MAX_LEN_TOP) ? MAX_LEN_TOP : MAX_NAME;

    t_phase           r_phase, n_phase;
    t_quote           r_qm, n_qm;
    logic [7:0]       r_cnt, n_cnt;
    logic [7:0]       r_lim, n_lim;
    logic [1:0][7:0]  r_h, n_h;
    logic [1:0]       r_hc, n_hc;
    logic             r_sp, n_sp;

    logic [MAX_LEN_W-1:0] m_cl, m_dec;
    logic [7:0]       lim_new, lim_a;
    logic             is_sptab, skip, active, qq;
    t_quote           qm_a, qm_b;
    t_phase           phase_after;
    logic             acc_req, acc_ok, sp_req;
    logic [7:0]       acc_char, cnt1, cnt_a;
    logic [1:0][7:0]  h_a;
    logic [1:0]       hc_a;
    logic             emit_a, sp_a;
    logic             close_mid, close_le, do_close;
    logic [3:0][7:0]  t;
    logic [1:0]       n;
    logic [7:0]       len;
    logic             full;
    logic [1:0]       k;
    t_result [RES_MAX-1:0] res;

    // token character limit, taken when a token starts
    always_comb begin
        m_cl    = (i_cfg.max_len > MAX_LEN_W'(CLAMP)) ? MAX_LEN_W'(CLAMP) : i_cfg.max_len;
        m_dec   = m_cl - MAX_LEN_W'(1);
        lim_new = (m_cl == '0) ? 8'd0 : ((m_dec > MAX_LEN_W'(255)) ? 8'hFF : m_dec[7:0]);
    end

    always_comb begin
        is_sptab = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
        skip     = (r_phase == PH_SKIP) && (is_sptab || (i_byte == CH_NL));
        active   = !skip && (r_phase != PH_DONE);
        qm_a     = (r_phase == PH_SKIP) ? QM_OUT : r_qm;
        lim_a    = (r_phase == PH_SKIP) ? lim_new : r_lim;
        qq       = (qm_a == QM_AFTER) && (i_byte == CH_DQ);
        qm_b     = ((qm_a == QM_AFTER) && !qq) ? QM_OUT : qm_a;

        acc_req  = active && (qq || (is_sptab && (qm_b != QM_OUT)) ||
                   (!is_sptab && (i_byte != CH_DQ) && (i_byte != CH_NL) &&
                    (i_byte != CH_NUL)));
        sp_req   = active && !qq && is_sptab && (qm_b != QM_OUT);
        acc_char = is_sptab ? CH_SPACE : i_byte;
        close_mid = active && !qq &&
                    ((is_sptab && (qm_b == QM_OUT)) || (i_byte == CH_NL) ||
                     (i_byte == CH_NUL));
        phase_after = active ? (close_mid ? PH_DONE : PH_TOKEN) : r_phase;
        close_le  = i_line_end && (phase_after == PH_TOKEN);
        do_close  = close_mid || close_le;

        // one accepted character
        acc_ok = acc_req && (r_cnt < lim_a);
        cnt1   = r_cnt + 8'd1;
        cnt_a  = acc_ok ? cnt1 : r_cnt;
        h_a    = r_h;
        hc_a   = r_hc;
        emit_a = 1'b0;
        if (acc_ok) begin
            if (cnt1 == lim_a) begin
                if (r_hc < 2'd2) begin
                    h_a[r_hc[0]] = acc_char;
                    hc_a = r_hc + 2'd1;
                end
            end else begin
                emit_a = (r_hc != 2'd0);
                h_a[0] = acc_char;
                hc_a   = 2'd1;
            end
        end
        sp_a = r_sp || (sp_req && acc_ok);

        // tail handling at token close
        t    = {8'd0, 8'd0, h_a[1], h_a[0]};
        n    = hc_a;
        len  = cnt_a;
        full = (cnt_a == lim_a) && (cnt_a != 8'd0);
        if (i_cfg.add_bsl && (len != 8'd0) && (n != 2'd0) && (t[n - 2'd1] != CH_BSL)) begin
            if (full) begin
                n   = n - 2'd1;
                len = len - 8'd1;
                if ((n == 2'd0) || (t[n - 2'd1] != CH_BSL)) begin
                    t[n] = CH_BSL;
                    n    = n + 2'd1;
                    len  = len + 8'd1;
                end
            end else begin
                t[n] = CH_BSL;
                n    = n + 2'd1;
                len  = len + 8'd1;
            end
        end
        if (i_cfg.strip_bsl && (len != 8'd0) && (n != 2'd0) && (t[n - 2'd1] == CH_BSL)) begin
            n   = n - 2'd1;
            len = len - 8'd1;
        end

        // result words in order
        res = '0;
        k   = 2'd0;
        if (emit_a) begin
            res[0].out_char   = r_h[0];
            res[0].char_valid = 1'b1;
            k = 2'd1;
        end
        if (do_close) begin
            if (n == 2'd0) begin
                res[k].token_done  = 1'b1;
                res[k].name_length = len;
                res[k].has_space   = sp_a;
                k = k + 2'd1;
            end else begin
                for (int i = 0; i < 2; i++) begin
                    if (2'(i) < n) begin
                        res[k].out_char   = t[i];
                        res[k].char_valid = 1'b1;
                        if (2'(i + 1) == n) begin
                            res[k].token_done  = 1'b1;
                            res[k].name_length = len;
                            res[k].has_space   = sp_a;
                        end
                        k = k + 2'd1;
                    end
                end
            end
        end

        // next state
        n_lim = (active && (r_phase == PH_SKIP)) ? lim_new : r_lim;
        if (do_close) begin
            n_cnt = 8'd0;
            n_hc  = 2'd0;
            n_h   = '0;
            n_sp  = 1'b0;
        end else begin
            n_cnt = cnt_a;
            n_hc  = hc_a;
            n_h   = h_a;
            n_sp  = sp_a;
        end
        n_phase = i_line_end ? PH_SKIP : phase_after;
        if (i_line_end || do_close) begin
            n_qm = QM_OUT;
        end else if (active) begin
            if (qq) begin
                n_qm = QM_IN;
            end else if (i_byte == CH_DQ) begin
                n_qm = (qm_b == QM_OUT) ? QM_IN : QM_AFTER;
            end else begin
                n_qm = qm_b;
            end
        end else begin
            n_qm = r_qm;
        end
    end

    assign o_push_cnt = i_valid ? k : 2'd0;
    assign o_push     = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_qm    <= QM_OUT;
            r_cnt   <= 8'd0;
            r_lim   <= 8'd0;
            r_h     <= '0;
            r_hc    <= 2'd0;
            r_sp    <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_qm    <= n_qm;
            r_cnt   <= n_cnt;
            r_lim   <= n_lim;
            r_h     <= n_h;
            r_hc    <= n_hc;
            r_sp    <= n_sp;
        end
    end

endmodule

FILE: rtl/qte_fifo.sv
module qte_fifo (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic [1:0]                               i_push_cnt,
    input  qte_pkg::t_result [qte_pkg::RES_MAX-1:0]  i_push,
    input  logic                                     i_pop,
    output qte_pkg::t_result                         o_head,
    output logic                                     o_not_empty,
    output logic [qte_pkg::FIFO_AW:0]                o_count
);
    import qte_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_count;
    logic                 pop_ok;

    assign pop_ok      = i_pop && (r_count != '0);
    assign o_head      = r_mem[r_rd];
    assign o_not_empty = (r_count != '0);
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES_MAX; i++) begin
            if (2'(i) < i_push_cnt) begin
                r_mem[r_wr + FIFO_AW'(i)] <= i_push[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push_cnt);
            r_rd    <= r_rd + FIFO_AW'(pop_ok);
            r_count <= r_count + (FIFO_AW + 1)'(i_push_cnt) - (FIFO_AW + 1)'(pop_ok);
        end
    end

endmodule

FILE: rtl/quoted_token_extractor.sv
// quoted_token_extractor
// input channel: one text byte per word (i_in_byte, i_line_end marks the last
// byte of a line), i_valid / o_stall. output channel: one name character or
// token close per word, o_valid / i_stall. apb port sets max_len,
// add_backslash and strip_backslash; write it only while the block is idle.
// an accepted byte is held in the input register, is decoded from there and
// its results land in an 8-word result queue whose head drives the output.
// throughput: one byte per cycle while o_stall is low; a byte gives up to
// three results (a held character plus the token tail), drained at one word
// per cycle by the output side while i_stall is low. o_stall rises while the
// queue holds more than two words, which keeps room for the byte in the input
// register and the next one.
// a line with a token gives exactly one token_done word, a blank line none.
// reset (synchronous, active low) empties the queue and the input register,
// returns to skipping leading blanks and loads max_len 256 with both
// backslash modes off. a stalled output word holds until taken.
module quoted_token_extractor #(
    parameter int MAX_NAME = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_line_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_out_char,
    output logic                        o_char_valid,
    output logic                        o_token_done,
    output logic [7:0]                  o_name_length,
    output logic                        o_has_space,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qte_pkg::ADDR_W-1:0]  paddr,
    input  logic [qte_pkg::DATA_W-1:0]  pwdata,
    output logic [qte_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import qte_pkg::*;

    t_cfg                  cfg;
    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_le;
    logic [1:0]            push_cnt;
    t_result [RES_MAX-1:0] push;
    t_result               head;
    logic                  not_empty;
    logic [FIFO_AW:0]      count;
    logic                  in_acc;

    assign o_stall = (count > (FIFO_AW + 1)'(STALL_LEVEL));
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_in_byte;
            r_in_le   <= i_line_end;
        end
    end

    qte_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qte_core #(
        .MAX_NAME (MAX_NAME)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_byte     (r_in_byte),
        .i_line_end (r_in_le),
        .i_cfg      (cfg),
        .o_push_cnt (push_cnt),
        .o_push     (push)
    );

    qte_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push      (push),
        .i_pop       (!i_stall),
        .o_head      (head),
        .o_not_empty (not_empty),
        .o_count     (count)
    );

    assign o_valid       = not_empty;
    assign o_out_char    = head.out_char;
    assign o_char_valid  = head.char_valid;
    assign o_token_done  = head.token_done;
    assign o_name_length = head.name_length;
    assign o_has_space   = head.has_space;

endmodule

FILE: rtl/qte_checker.sv
module qte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [7:0] o_out_char,
    input logic       o_char_valid,
    input logic       o_token_done,
    input logic [7:0] o_name_length,
    input logic       o_has_space
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid &&
        $stable({o_out_char, o_char_valid, o_token_done, o_name_length, o_has_space}))
        else $error("output word changed under stall");

    // length and space flag only on the closing word
    a_close_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_token_done |-> (o_name_length == 8'd0) && !o_has_space)
        else $error("length or space flag on a non-closing word");

    // a word without a character is an empty-tail close
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_char_valid |-> o_token_done && (o_out_char == 8'd0))
        else $error("empty word that does not close the token");

    // reset empties the queue and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue not empty after reset");

endmodule

bind quoted_token_extractor qte_checker u_qte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_stall       (o_stall),
    .o_out_char    (o_out_char),
    .o_char_valid  (o_char_valid),
    .o_token_done  (o_token_done),
    .o_name_length (o_name_length),
    .o_has_space   (o_has_space)
);
